// ----- sv/ihp_pkg.sv -----
// Shared types and codes for the indexed min-heap.
package ihp_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SETKEY = 2'd1;
    localparam logic [1:0] OP_DELMIN = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_EXISTS = 3'd2;
    localparam logic [2:0] ST_ABSENT = 3'd3;
    localparam logic [2:0] ST_EMPTY  = 3'd4;

    typedef struct packed {
        logic [1:0]         operation;
        logic [8:0]         item_id;
        logic signed [31:0] key_value;
        logic [31:0]        payload_in;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [8:0]         out_id;
        logic signed [31:0] out_key;
        logic [31:0]        out_payload;
    } t_out_item;

    typedef struct packed {
        logic [8:0]         id;
        logic signed [31:0] key;
        logic [31:0]        pay;
    } t_slot;

endpackage

// ----- sv/indexed_min_heap.sv -----
// Indexed binary min-heap: sequencer, slot memory and id position table.
//
// Input channel i_in (valid/ready) carries one operation: insert, set key,
// delete minimum or remove by id. Each transaction yields exactly one result
// transaction on o_out (valid/ready) with a status and the affected entry.
// The block works on one transaction at a time; o_in_ready is high only
// while the sequencer is idle.
// Sequence: an id lookup, an entry read where the operation needs one, then
// the percolation. Moving up reads the parent and then compares; moving down
// reads both children and then compares, all through the single read port of
// the slot memory.
// Reset: entry count goes to zero, capacity to 256, and a clearing pass
// writes every id position entry to zero, one per cycle, with o_in_ready
// low. Configuration writes are taken at any time outside reset.
// Stall: a finished result waits in the output register; the next
// transaction is accepted meanwhile, but its result holds in the
// sequencer until the output register is free.
module indexed_min_heap #(
    parameter int HEAP_SLOTS = 256,
    parameter int ID_SPACE   = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ihp_pkg::t_in_item i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ihp_pkg::t_out_item o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [8:0]        i_cfg_data
);

    localparam int SW  = $clog2(HEAP_SLOTS + 1);
    localparam int IDW = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
    localparam logic [IDW-1:0] LAST_ID = IDW'(ID_SPACE - 1);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_LOOK   = 4'd2;
    localparam logic [3:0] S_ENT    = 4'd3;
    localparam logic [3:0] S_LAST   = 4'd4;
    localparam logic [3:0] S_UP_RD  = 4'd5;
    localparam logic [3:0] S_UP_CMP = 4'd6;
    localparam logic [3:0] S_DN_RD  = 4'd7;
    localparam logic [3:0] S_DN_RD2 = 4'd8;
    localparam logic [3:0] S_DN_CMP = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    logic [3:0]         r_state, n_state;
    logic [IDW-1:0]     r_clr, n_clr;
    logic [SW-1:0]      r_count, n_count;
    logic [SW-1:0]      r_s, n_s;
    logic [8:0]         r_cap;
    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_op, n_op;
    logic [8:0]         r_id, n_id;
    logic signed [31:0] r_key, n_key;
    logic [31:0]        r_pay, n_pay;
    ihp_pkg::t_slot     r_e, n_e;
    logic signed [31:0] r_old, n_old;
    ihp_pkg::t_slot     r_child, n_child;
    logic [SW-1:0]      r_cidx, n_cidx;
    logic               r_one, n_one;
    ihp_pkg::t_out_item r_res, n_res;
    ihp_pkg::t_out_item r_out, n_out;

    logic               slot_we;
    logic [SW-1:0]      slot_waddr, slot_raddr;
    ihp_pkg::t_slot     slot_wdata, slot_rd;
    logic               pos_we;
    logic [IDW-1:0]     pos_waddr, pos_raddr;
    logic [SW-1:0]      pos_wdata, pos_rd;

    logic [SW:0]        w_child;
    logic               w_id_ok, w_pos_ok, w_full, w_pick;
    ihp_pkg::t_slot     w_ch;
    logic [SW-1:0]      w_ci;

    ihp_ram #(.WIDTH($bits(ihp_pkg::t_slot)), .DEPTH(HEAP_SLOTS + 1)) u_slots (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rd)
    );

    ihp_ram #(.WIDTH(SW), .DEPTH(ID_SPACE)) u_pos (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rd)
    );

    assign w_child  = {r_s, 1'b0};
    assign w_id_ok  = 32'(r_id) < 32'(ID_SPACE);
    assign w_pos_ok = w_id_ok && (pos_rd != '0) && (pos_rd <= r_count);
    assign w_full   = (32'(r_count) >= 32'(HEAP_SLOTS)) || (32'(r_count) >= 32'(r_cap));
    assign w_pick   = !r_one && (slot_rd.key < r_child.key);
    assign w_ch     = w_pick ? slot_rd : r_child;
    assign w_ci     = w_pick ? (r_cidx + SW'(1)) : r_cidx;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_count     = r_count;
        n_s         = r_s;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_id        = r_id;
        n_key       = r_key;
        n_pay       = r_pay;
        n_e         = r_e;
        n_old       = r_old;
        n_child     = r_child;
        n_cidx      = r_cidx;
        n_one       = r_one;
        n_res       = r_res;
        n_out       = r_out;
        slot_we     = 1'b0;
        slot_waddr  = r_s;
        slot_wdata  = r_e;
        slot_raddr  = '0;
        pos_we      = 1'b0;
        pos_waddr   = IDW'(r_e.id);
        pos_wdata   = r_s;
        pos_raddr   = IDW'(i_in.item_id);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                pos_we    = 1'b1;
                pos_waddr = r_clr;
                pos_wdata = '0;
                n_clr     = r_clr + IDW'(1);
                if (r_clr == LAST_ID) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in.operation;
                    n_id    = i_in.item_id;
                    n_key   = i_in.key_value;
                    n_pay   = i_in.payload_in;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_res   = '0;
                n_state = S_FIN;
                case (r_op)
                    ihp_pkg::OP_INSERT: begin
                        if (w_full) begin
                            n_res.status = ihp_pkg::ST_FULL;
                        end else if (!w_id_ok) begin
                            n_res.status = ihp_pkg::ST_ABSENT;
                        end else if (pos_rd != '0) begin
                            n_res.status = ihp_pkg::ST_EXISTS;
                        end else begin
                            n_count = r_count + SW'(1);
                            n_s     = r_count + SW'(1);
                            n_e     = '{id: r_id, key: r_key, pay: r_pay};
                            n_res   = '{status: ihp_pkg::ST_OK, out_id: r_id,
                                        out_key: r_key, out_payload: r_pay};
                            n_state = S_UP_RD;
                        end
                    end
                    ihp_pkg::OP_DELMIN: begin
                        if (r_count == '0) begin
                            n_res.status = ihp_pkg::ST_EMPTY;
                        end else begin
                            slot_raddr = SW'(1);
                            n_s        = SW'(1);
                            n_state    = S_ENT;
                        end
                    end
                    default: begin
                        if (!w_pos_ok) begin
                            n_res.status = ihp_pkg::ST_ABSENT;
                        end else begin
                            slot_raddr = pos_rd;
                            n_s        = pos_rd;
                            n_state    = S_ENT;
                        end
                    end
                endcase
            end
            S_ENT: begin
                if (r_op == ihp_pkg::OP_SETKEY) begin
                    n_e   = '{id: slot_rd.id, key: r_key, pay: slot_rd.pay};
                    n_res = '{status: ihp_pkg::ST_OK, out_id: r_id,
                              out_key: r_key, out_payload: slot_rd.pay};
                    n_state = (slot_rd.key < r_key) ? S_DN_RD : S_UP_RD;
                end else begin
                    n_res = '{status: ihp_pkg::ST_OK, out_id: slot_rd.id,
                              out_key: slot_rd.key, out_payload: slot_rd.pay};
                    n_old     = slot_rd.key;
                    pos_we    = 1'b1;
                    pos_waddr = IDW'(slot_rd.id);
                    pos_wdata = '0;
                    n_count   = r_count - SW'(1);
                    if (r_s == r_count) begin
                        n_state = S_FIN;
                    end else begin
                        slot_raddr = r_count;
                        n_state    = S_LAST;
                    end
                end
            end
            S_LAST: begin
                n_e     = slot_rd;
                n_state = (r_old < slot_rd.key) ? S_DN_RD : S_UP_RD;
            end
            S_UP_RD: begin
                if (r_s == SW'(1)) begin
                    slot_we = 1'b1;
                    pos_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    slot_raddr = r_s >> 1;
                    n_state    = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                slot_we = 1'b1;
                pos_we  = 1'b1;
                if (r_e.key < slot_rd.key) begin
                    slot_wdata = slot_rd;
                    pos_waddr  = IDW'(slot_rd.id);
                    n_s        = r_s >> 1;
                    n_state    = S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DN_RD: begin
                if (w_child > {1'b0, r_count}) begin
                    slot_we = 1'b1;
                    pos_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    slot_raddr = SW'(w_child);
                    n_state    = S_DN_RD2;
                end
            end
            S_DN_RD2: begin
                n_child = slot_rd;
                n_cidx  = SW'(w_child);
                n_one   = (w_child == {1'b0, r_count});
                slot_raddr = SW'(w_child) + SW'(1);
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                slot_we = 1'b1;
                pos_we  = 1'b1;
                if (w_ch.key < r_e.key) begin
                    slot_wdata = w_ch;
                    pos_waddr  = IDW'(w_ch.id);
                    n_s        = w_ci;
                    n_state    = S_DN_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_count     <= '0;
            r_cap       <= 9'd256;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s     <= n_s;
        r_op    <= n_op;
        r_id    <= n_id;
        r_key   <= n_key;
        r_pay   <= n_pay;
        r_e     <= n_e;
        r_old   <= n_old;
        r_child <= n_child;
        r_cidx  <= n_cidx;
        r_one   <= n_one;
        r_res   <= n_res;
        r_out   <= n_out;
    end

endmodule

// ----- sv/ihp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ihp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ihp_checker.sv -----
// Port-level checker for the indexed min-heap, bound to the top level.
module ihp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input ihp_pkg::t_in_item  i_in,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ihp_pkg::t_out_item o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_ready)
        else $error("input ready during clearing pass");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ihp_pkg::ST_OK |->
        o_out.out_id == '0 && o_out.out_key == '0 && o_out.out_payload == '0)
        else $error("failed result carries entry data");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.status <= ihp_pkg::ST_EMPTY)
        else $error("undefined status code");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transaction accepted while busy");

endmodule

bind indexed_min_heap ihp_checker u_ihp_checker (.*);

// ----- sim/tb_indexed_min_heap.sv -----
// Testbench for the indexed min-heap: directed table, random operations, scoreboard.
`timescale 1ns / 100ps

module tb_indexed_min_heap;

    localparam int SLOTS = 256;
    localparam int IDS = 512;
    localparam int RANDOM_ITEMS = 700;
    localparam longint CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    ihp_pkg::t_in_item i_in;
    logic o_out_valid;
    logic i_out_ready;
    ihp_pkg::t_out_item o_out;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [8:0] i_cfg_data;

    indexed_min_heap dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // shadow heap
    logic signed [31:0] m_key [0:SLOTS];
    logic [8:0]         m_id  [0:SLOTS];
    logic [31:0]        m_pay [0:SLOTS];
    int unsigned        m_pos [0:IDS-1];
    int unsigned        m_count;
    logic [8:0]         m_cap;

    ihp_pkg::t_out_item expected_q[$];
    int errors;
    int results_seen;
    int ops_sent;
    int ops_by_kind[4];
    longint cycles;
    logic drain_ready;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     expected_q.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input ihp_pkg::t_out_item got,
                                   input ihp_pkg::t_out_item want);
        errors++;
        $display({"mismatch %s: got st=%0d id=%0d key=%0d pay=%h, ",
                  "want st=%0d id=%0d key=%0d pay=%h"},
                 what, got.status, got.out_id, got.out_key, got.out_payload,
                 want.status, want.out_id, want.out_key, want.out_payload);
    endtask

    task automatic place(input int unsigned s, input logic [8:0] id,
                         input logic signed [31:0] key, input logic [31:0] pay);
        m_id[s] = id;
        m_key[s] = key;
        m_pay[s] = pay;
        m_pos[id] = s;
    endtask

    task automatic bubble_up(input int unsigned start);
        int unsigned s;
        logic [8:0] id;
        logic signed [31:0] key;
        logic [31:0] pay;
        s = start;
        id = m_id[s]; key = m_key[s]; pay = m_pay[s];
        while (s > 1 && key < m_key[s/2]) begin
            place(s, m_id[s/2], m_key[s/2], m_pay[s/2]);
            s = s / 2;
        end
        place(s, id, key, pay);
    endtask

    task automatic bubble_down(input int unsigned start);
        int unsigned s, c;
        logic [8:0] id;
        logic signed [31:0] key;
        logic [31:0] pay;
        s = start;
        id = m_id[s]; key = m_key[s]; pay = m_pay[s];
        while (s * 2 <= m_count) begin
            c = s * 2;
            if (c != m_count && m_key[c+1] < m_key[c]) c++;
            if (!(m_key[c] < key)) break;
            place(s, m_id[c], m_key[c], m_pay[c]);
            s = c;
        end
        place(s, id, key, pay);
    endtask

    task automatic extract_slot(input int unsigned s);
        logic signed [31:0] old_key;
        int unsigned last;
        old_key = m_key[s];
        last = m_count;
        m_pos[m_id[s]] = 0;
        m_count--;
        if (s != last) begin
            place(s, m_id[last], m_key[last], m_pay[last]);
            if (old_key < m_key[s]) bubble_down(s);
            else if (m_key[s] < old_key) bubble_up(s);
        end
    endtask

    function automatic int unsigned eff_cap();
        return (m_cap > SLOTS) ? SLOTS : m_cap;
    endfunction

    task automatic heap_apply(input ihp_pkg::t_in_item it, output ihp_pkg::t_out_item r);
        int unsigned pos;
        logic signed [31:0] old;
        r = '0;
        pos = m_pos[it.item_id];
        case (it.operation)
            ihp_pkg::OP_INSERT: begin
                if (m_count >= eff_cap()) r.status = ihp_pkg::ST_FULL;
                else if (pos != 0) r.status = ihp_pkg::ST_EXISTS;
                else begin
                    m_count++;
                    place(m_count, it.item_id, it.key_value, it.payload_in);
                    bubble_up(m_count);
                    r = '{ihp_pkg::ST_OK, it.item_id, it.key_value, it.payload_in};
                end
            end
            ihp_pkg::OP_SETKEY: begin
                if (pos == 0 || pos > m_count) r.status = ihp_pkg::ST_ABSENT;
                else begin
                    old = m_key[pos];
                    m_key[pos] = it.key_value;
                    r = '{ihp_pkg::ST_OK, it.item_id, it.key_value, m_pay[pos]};
                    if (old < it.key_value) bubble_down(pos);
                    else if (it.key_value < old) bubble_up(pos);
                end
            end
            ihp_pkg::OP_DELMIN: begin
                if (m_count == 0) r.status = ihp_pkg::ST_EMPTY;
                else begin
                    r = '{ihp_pkg::ST_OK, m_id[1], m_key[1], m_pay[1]};
                    extract_slot(1);
                end
            end
            default: begin
                if (pos == 0 || pos > m_count) r.status = ihp_pkg::ST_ABSENT;
                else begin
                    r = '{ihp_pkg::ST_OK, it.item_id, m_key[pos], m_pay[pos]};
                    extract_slot(pos);
                end
            end
        endcase
    endtask

    // result side
    always @(posedge i_clk) begin
        ihp_pkg::t_out_item want;
        if (i_rst_n) begin
            if (drain_ready) i_out_ready <= 1'b1;
            else if ($urandom_range(0, 9) < 7) i_out_ready <= 1'b1;
            else i_out_ready <= ($urandom_range(0, 3) == 0);
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", o_out, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (o_out.status !== want.status) report_mismatch("status", o_out, want);
                    else if (o_out.out_id !== want.out_id) report_mismatch("id", o_out, want);
                    else if (o_out.out_key !== want.out_key) report_mismatch("key", o_out, want);
                    else if (o_out.out_payload !== want.out_payload)
                        report_mismatch("payload", o_out, want);
                end
            end
        end
    end

    task automatic send_op(input ihp_pkg::t_in_item it, input bit has_want,
                           input ihp_pkg::t_out_item want);
        ihp_pkg::t_out_item r;
        i_in <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        heap_apply(it, r);
        if (has_want && r != want) report_mismatch("table row", r, want);
        expected_q.push_back(r);
        ops_sent++;
        ops_by_kind[it.operation]++;
        if ($urandom_range(0, 9) < 6) begin
            // keep valid high for the next transaction
        end else begin
            i_in_valid <= 1'b0;
            if ($urandom_range(0, 9) < 8) repeat ($urandom_range(1, 3)) @(posedge i_clk);
            else repeat ($urandom_range(10, 40)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [8:0] value);
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        m_cap = value;
    endtask

    function automatic ihp_pkg::t_in_item mk(input logic [1:0] op, input logic [8:0] id,
                                             input logic signed [31:0] key,
                                             input logic [31:0] pay);
        ihp_pkg::t_in_item it;
        it = '{op, id, key, pay};
        return it;
    endfunction

    typedef struct {
        ihp_pkg::t_in_item  item;
        bit                 has_want;
        ihp_pkg::t_out_item want;
    } t_row;

    t_row directed_rows[$];

    task automatic add_row(input ihp_pkg::t_in_item it, input bit hw,
                           input ihp_pkg::t_out_item w);
        t_row r;
        r.item = it; r.has_want = hw; r.want = w;
        directed_rows.push_back(r);
    endtask

    function automatic logic signed [31:0] rand_key(input int spread);
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            default: return $signed($urandom_range(0, spread)) - spread / 2;
        endcase
    endfunction

    // pick a random id, mostly from a small pool so ops hit live entries
    function automatic logic [8:0] rand_id(input int pool);
        if ($urandom_range(0, 9) == 0) return 9'($urandom_range(0, IDS - 1));
        return 9'($urandom_range(0, pool - 1));
    endfunction

    task automatic random_phase(input int n, input int pool, input int ins_bias);
        int k;
        logic [1:0] op;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < ins_bias) op = ihp_pkg::OP_INSERT;
            else op = 2'($urandom_range(1, 3));
            if (k % 5 == 0 && $urandom_range(0, 1) == 0) op = 2'($urandom_range(0, 3));
            send_op(mk(op, (op == ihp_pkg::OP_DELMIN && $urandom_range(0, 1)) ? 9'($urandom)
                              : rand_id(pool),
                       (pool < 40) ? rand_key(16) : rand_key(2000000), $urandom), 0, '0);
        end
    endtask

    initial begin
        int i;
        cycles = 0;
        errors = 0;
        results_seen = 0;
        ops_sent = 0;
        drain_ready = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        for (i = 0; i < IDS; i++) m_pos[i] = 0;
        for (i = 0; i <= SLOTS; i++) begin
            m_key[i] = '0; m_id[i] = '0; m_pay[i] = '0;
        end
        m_count = 0;
        m_cap = 9'd256;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(mk(ihp_pkg::OP_DELMIN, 9'd0, 0, 0), 1, '{ihp_pkg::ST_EMPTY, 9'd0, 0, 0});
        add_row(mk(ihp_pkg::OP_SETKEY, 9'd5, 3, 0), 1, '{ihp_pkg::ST_ABSENT, 9'd0, 0, 0});
        add_row(mk(ihp_pkg::OP_REMOVE, 9'd511, 0, 0), 1, '{ihp_pkg::ST_ABSENT, 9'd0, 0, 0});
        add_row(mk(ihp_pkg::OP_INSERT, 9'd511, 32'sh7fffffff, 32'hffffffff), 1,
                '{ihp_pkg::ST_OK, 9'd511, 32'sh7fffffff, 32'hffffffff});
        add_row(mk(ihp_pkg::OP_INSERT, 9'd511, 1, 1), 1, '{ihp_pkg::ST_EXISTS, 9'd0, 0, 0});
        add_row(mk(ihp_pkg::OP_INSERT, 9'd0, 32'sh80000000, 32'h0), 1,
                '{ihp_pkg::ST_OK, 9'd0, 32'sh80000000, 32'h0});
        add_row(mk(ihp_pkg::OP_INSERT, 9'd170, 5, 32'haaaaaaaa), 0, '0);
        add_row(mk(ihp_pkg::OP_INSERT, 9'd341, 5, 32'h55555555), 0, '0);
        add_row(mk(ihp_pkg::OP_INSERT, 9'd7, -1, 32'h1234), 0, '0);
        add_row(mk(ihp_pkg::OP_SETKEY, 9'd7, -1, 0), 0, '0);
        add_row(mk(ihp_pkg::OP_SETKEY, 9'd0, 32'sh7fffffff, 0), 0, '0);
        add_row(mk(ihp_pkg::OP_SETKEY, 9'd511, 32'sh80000000, 0), 0, '0);
        add_row(mk(ihp_pkg::OP_REMOVE, 9'd341, 0, 0), 0, '0);
        add_row(mk(ihp_pkg::OP_REMOVE, 9'd0, 0, 0), 0, '0);
        add_row(mk(ihp_pkg::OP_DELMIN, 9'd300, 0, 0), 0, '0);
        add_row(mk(ihp_pkg::OP_DELMIN, 9'd0, 0, 0), 0, '0);
        add_row(mk(ihp_pkg::OP_DELMIN, 9'd0, 0, 0), 0, '0);
        add_row(mk(ihp_pkg::OP_DELMIN, 9'd0, 0, 0), 1, '{ihp_pkg::ST_EMPTY, 9'd0, 0, 0});
        foreach (directed_rows[r])
            send_op(directed_rows[r].item, directed_rows[r].has_want, directed_rows[r].want);
        wait_drained();

        write_capacity(9'd1);
        send_op(mk(ihp_pkg::OP_INSERT, 9'd3, 10, 1), 0, '0);
        send_op(mk(ihp_pkg::OP_INSERT, 9'd4, 9, 2), 1, '{ihp_pkg::ST_FULL, 9'd0, 0, 0});
        send_op(mk(ihp_pkg::OP_INSERT, 9'd3, 9, 2), 1, '{ihp_pkg::ST_FULL, 9'd0, 0, 0});
        wait_drained();
        write_capacity(9'd0);
        send_op(mk(ihp_pkg::OP_INSERT, 9'd9, 9, 9), 1, '{ihp_pkg::ST_FULL, 9'd0, 0, 0});
        send_op(mk(ihp_pkg::OP_DELMIN, 9'd0, 0, 0), 1, '{ihp_pkg::ST_OK, 9'd3, 10, 1});
        wait_drained();

        write_capacity(9'd6);
        random_phase(150, 12, 45);
        wait_drained();
        write_capacity(9'd511);
        random_phase(300, 400, 70);
        wait_drained();
        write_capacity(9'd3);
        random_phase(60, 10, 40);
        wait_drained();
        write_capacity(9'd256);
        random_phase(190, 300, 30);

        drain_ready = 1'b1;
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("ran %0d operations (insert %0d, set key %0d, delete min %0d, remove %0d)",
                 ops_sent, ops_by_kind[0], ops_by_kind[1], ops_by_kind[2], ops_by_kind[3]);
        $display("capacities 0, 1, 3, 6, 256, 511 exercised; %0d results checked", results_seen);
        if (errors == 0 && expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- indexed_min_heap.f -----
sv/ihp_pkg.sv
sv/ihp_ram.sv
sv/indexed_min_heap.sv
sv/ihp_checker.sv
sim/tb_indexed_min_heap.sv
